@@ src/trwl_pkg.sv @@
// ----------------------------------------------------------------------------
// trwl_pkg
// Shared types and constants for the ticket-ordered reader/writer lock unit.
// ----------------------------------------------------------------------------
package trwl_pkg;

    localparam int MAX_READERS = 16;
    localparam int MAX_SKIPPED = 16;
    localparam int TICKET_BITS = 16;

    localparam int SCAN_N = (MAX_READERS > MAX_SKIPPED) ? MAX_READERS : MAX_SKIPPED;
    localparam int RIDX_W = (MAX_READERS > 1) ? $clog2(MAX_READERS) : 1;
    localparam int SIDX_W = (MAX_SKIPPED > 1) ? $clog2(MAX_SKIPPED) : 1;
    localparam int CNT_W  = (SCAN_N > 1) ? $clog2(SCAN_N) : 1;

    typedef logic [TICKET_BITS-1:0] t_ticket;

    typedef enum logic [2:0] {
        OP_ACQUIRE     = 3'd0,
        OP_TRY_ACQUIRE = 3'd1,
        OP_POLL_GRANT  = 3'd2,
        OP_CANCEL      = 3'd3,
        OP_RELEASE     = 3'd4
    } t_opcode;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_DEADLOCK = 3'd1;
    localparam logic [2:0] ST_BUSY     = 3'd2;
    localparam logic [2:0] ST_WAIT     = 3'd3;
    localparam logic [2:0] ST_NOTHELD  = 3'd4;
    localparam logic [2:0] ST_FULL     = 3'd5;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [14:0] requester_id;
        logic        want_write;
        logic [15:0] ticket_in;
    } t_in_word;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] ticket_out;
        logic        clear_lock_mark;
        logic        wake_waiters;
    } t_out_word;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_EXEC,
        S_ADV_SCAN,
        S_ADV_CHK,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic scan;
        logic exec;
        logic adv_scan;
        logic adv_chk;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        logic scan_last;
        logic need_adv;
        logic adv_found;
    } t_dp_stat;

endpackage

@@ src/trwl_ctrl.sv @@
// ----------------------------------------------------------------------------
// trwl_ctrl
// Sequencer: table scan, command execution, serving-ticket advance, result.
// ----------------------------------------------------------------------------
module trwl_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  trwl_pkg::t_dp_stat  i_stat,
    output trwl_pkg::t_dp_cmd   o_cmd,
    output logic                o_busy
);
    import trwl_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:     if (i_start) n_state = S_SCAN;
            S_SCAN:     if (i_stat.scan_last) n_state = S_EXEC;
            S_EXEC:     n_state = i_stat.need_adv ? S_ADV_SCAN : S_DONE;
            S_ADV_SCAN: if (i_stat.scan_last) n_state = S_ADV_CHK;
            S_ADV_CHK:  n_state = i_stat.adv_found ? S_ADV_SCAN : S_DONE;
            S_DONE:     n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd  = '0;
        o_busy = (r_state != S_IDLE);
        unique case (r_state)
            S_IDLE:     o_cmd.load     = i_start;
            S_SCAN:     o_cmd.scan     = 1'b1;
            S_EXEC:     o_cmd.exec     = 1'b1;
            S_ADV_SCAN: o_cmd.adv_scan = 1'b1;
            S_ADV_CHK:  o_cmd.adv_chk  = 1'b1;
            S_DONE:     o_cmd.finish   = 1'b1;
            default:    o_cmd          = '0;
        endcase
    end

endmodule

@@ src/trwl_datapath.sv @@
// ----------------------------------------------------------------------------
// trwl_datapath
// Lock state, reader and skipped tables, scan registers and result register.
// ----------------------------------------------------------------------------
module trwl_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  trwl_pkg::t_in_word  i_cmd_word,
    input  trwl_pkg::t_dp_cmd   i_cmd,
    output trwl_pkg::t_dp_stat  o_stat,
    output trwl_pkg::t_out_word o_res,
    output logic                o_strobe
);
    import trwl_pkg::*;

    t_ticket                r_next, r_serving;
    logic                   r_wp;
    logic [14:0]            r_wid;
    logic [MAX_READERS-1:0] r_rv;
    logic [14:0]            r_rid [MAX_READERS];
    logic [MAX_SKIPPED-1:0] r_sv;
    t_ticket                r_st  [MAX_SKIPPED];

    t_in_word               r_in;
    logic [CNT_W-1:0]       r_cnt;
    logic                   r_rfound, r_rfree_ok, r_sfound, r_sfree_ok;
    logic [RIDX_W-1:0]      r_ridx, r_rfree;
    logic [SIDX_W-1:0]      r_sidx, r_sfree;
    logic [1:0]             r_rcnt;
    t_out_word              r_word, r_res;
    logic                   r_strobe;

    t_ticket           tin, key, ofs, span;
    logic [RIDX_W-1:0] ri;
    logic [SIDX_W-1:0] si;
    logic              r_in_rng, s_in_rng, holds, outst, any_r;
    t_out_word         c_word;
    logic              c_next_inc, c_gw, c_gr, c_ins, c_relw, c_relr, c_adv;

    assign tin      = r_in.ticket_in[TICKET_BITS-1:0];
    assign key      = i_cmd.adv_scan ? r_serving : tin;
    assign ri       = r_cnt[RIDX_W-1:0];
    assign si       = r_cnt[SIDX_W-1:0];
    assign r_in_rng = ({1'b0, r_cnt} < (CNT_W+1)'(MAX_READERS));
    assign s_in_rng = ({1'b0, r_cnt} < (CNT_W+1)'(MAX_SKIPPED));
    assign holds    = (r_wp && r_wid == r_in.requester_id) || r_rfound;
    assign ofs      = tin - r_serving;
    assign span     = r_next - r_serving;
    assign outst    = ofs < span;
    assign any_r    = (r_rcnt != 2'd0);

    always_comb begin
        c_word     = '0;
        c_next_inc = 1'b0;
        c_gw       = 1'b0;
        c_gr       = 1'b0;
        c_ins      = 1'b0;
        c_relw     = 1'b0;
        c_relr     = 1'b0;
        c_adv      = 1'b0;
        c_word.status = ST_OK;
        unique case (r_in.opcode)
            OP_ACQUIRE: begin
                if (holds) begin
                    c_word.status = ST_DEADLOCK;
                end else if (t_ticket'(r_next + 1'b1) == r_serving) begin
                    c_word.status = ST_FULL;
                end else begin
                    c_word.ticket_out = 16'(r_next);
                    c_next_inc        = 1'b1;
                end
            end
            OP_TRY_ACQUIRE: begin
                if (holds || r_next != r_serving || r_wp || (r_in.want_write && any_r)) begin
                    c_word.status = ST_BUSY;
                end else if (r_in.want_write) begin
                    c_gw = 1'b1;
                    c_word.wake_waiters = 1'b1;
                end else if (!r_rfree_ok) begin
                    c_word.status = ST_FULL;
                end else begin
                    c_gr = 1'b1;
                    c_word.wake_waiters = 1'b1;
                end
            end
            OP_POLL_GRANT: begin
                if (!outst || tin != r_serving || r_wp || (r_in.want_write && any_r)) begin
                    c_word.status = ST_WAIT;
                end else if (r_in.want_write) begin
                    c_gw  = 1'b1;
                    c_adv = 1'b1;
                end else if (!r_rfree_ok) begin
                    c_word.status = ST_FULL;
                end else begin
                    c_gr  = 1'b1;
                    c_adv = 1'b1;
                    c_word.wake_waiters = 1'b1;
                end
            end
            OP_CANCEL: begin
                if (!outst) begin
                    c_word.status = ST_NOTHELD;
                end else if (tin == r_serving) begin
                    c_adv = 1'b1;
                    c_word.wake_waiters = 1'b1;
                end else if (!r_sfound) begin
                    if (!r_sfree_ok) c_word.status = ST_FULL;
                    else c_ins = 1'b1;
                end
            end
            OP_RELEASE: begin
                if (r_wp && r_wid == r_in.requester_id) begin
                    c_relw = 1'b1;
                    c_word.clear_lock_mark = 1'b1;
                    c_word.wake_waiters    = 1'b1;
                end else if (!r_rfound) begin
                    c_word.status = ST_NOTHELD;
                end else begin
                    c_relr = 1'b1;
                    c_word.clear_lock_mark = (r_rcnt < 2'd2);
                    c_word.wake_waiters    = 1'b1;
                end
            end
            default: c_word.status = ST_NOTHELD;
        endcase
    end

    assign o_stat.scan_last = (r_cnt == CNT_W'(SCAN_N - 1));
    assign o_stat.need_adv  = c_adv;
    assign o_stat.adv_found = r_sfound;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next    <= '0;
            r_serving <= '0;
            r_wp      <= 1'b0;
            r_wid     <= '0;
            r_rv      <= '0;
            r_sv      <= '0;
            r_strobe  <= 1'b0;
        end else begin
            r_strobe <= i_cmd.finish;
            if (i_cmd.exec) begin
                if (c_next_inc) r_next <= r_next + 1'b1;
                if (c_gw) begin
                    r_wp  <= 1'b1;
                    r_wid <= r_in.requester_id;
                end
                if (c_relw) begin
                    r_wp  <= 1'b0;
                    r_wid <= '0;
                end
                if (c_gr) r_rv[r_rfree] <= 1'b1;
                if (c_relr) r_rv[r_ridx] <= 1'b0;
                if (c_ins) r_sv[r_sfree] <= 1'b1;
                if (c_adv) r_serving <= r_serving + 1'b1;
            end
            if (i_cmd.adv_chk && r_sfound) begin
                r_sv[r_sidx] <= 1'b0;
                r_serving    <= r_serving + 1'b1;
            end
        end
    end

    // tables and scan registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_in       <= i_cmd_word;
            r_cnt      <= '0;
            r_rfound   <= 1'b0;
            r_rfree_ok <= 1'b0;
            r_sfound   <= 1'b0;
            r_sfree_ok <= 1'b0;
            r_rcnt     <= '0;
        end
        if (i_cmd.scan || i_cmd.adv_scan) begin
            r_cnt <= r_cnt + 1'b1;
            if (s_in_rng && r_sv[si] && r_st[si] == key && !r_sfound) begin
                r_sfound <= 1'b1;
                r_sidx   <= si;
            end
        end
        if (i_cmd.scan) begin
            if (r_in_rng) begin
                if (r_rv[ri] && r_rid[ri] == r_in.requester_id && !r_rfound) begin
                    r_rfound <= 1'b1;
                    r_ridx   <= ri;
                end
                if (!r_rv[ri] && !r_rfree_ok) begin
                    r_rfree_ok <= 1'b1;
                    r_rfree    <= ri;
                end
                if (r_rv[ri] && r_rcnt != 2'd2) r_rcnt <= r_rcnt + 1'b1;
            end
            if (s_in_rng && !r_sv[si] && !r_sfree_ok) begin
                r_sfree_ok <= 1'b1;
                r_sfree    <= si;
            end
        end
        if (i_cmd.exec) begin
            r_word   <= c_word;
            r_cnt    <= '0;
            r_sfound <= 1'b0;
            if (c_gr) r_rid[r_rfree] <= r_in.requester_id;
            if (c_ins) r_st[r_sfree] <= tin;
        end
        if (i_cmd.adv_chk) begin
            r_cnt    <= '0;
            r_sfound <= 1'b0;
        end
        if (i_cmd.finish) r_res <= r_word;
    end

    assign o_res    = r_res;
    assign o_strobe = r_strobe;

endmodule

@@ src/ticket_reader_writer_lock_unit.sv @@
// ----------------------------------------------------------------------------
// ticket_reader_writer_lock_unit
// Ticket-ordered reader/writer lock manager, one command word per start.
// ----------------------------------------------------------------------------
// A command word is taken when start is high and busy is low; busy then stays
// high until the result word has been produced, and the result appears on
// o_res for one cycle with o_strobe, which must be captured as it comes.
// Every command first scans the reader and skipped tables one entry per cycle,
// then executes; a command that advances the serving ticket rescans the
// skipped table once per consumed skipped ticket plus once more.
module ticket_reader_writer_lock_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  trwl_pkg::t_in_word  i_cmd,
    output logic                o_strobe,
    output trwl_pkg::t_out_word o_res
);
    import trwl_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    trwl_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (dp_stat),
        .o_cmd   (dp_cmd),
        .o_busy  (busy)
    );

    trwl_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd_word (i_cmd),
        .i_cmd      (dp_cmd),
        .o_stat     (dp_stat),
        .o_res      (o_res),
        .o_strobe   (o_strobe)
    );

`ifndef ASSERT_OFF
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accept");
    a_strobe_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(busy))
        else $error("result without command");
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("result repeated");
`endif

endmodule

@@ tb/tb_ticket_reader_writer_lock_unit.sv @@
// ----------------------------------------------------------------------------
// tb_ticket_reader_writer_lock_unit
// Self-checking bench for the ticket-ordered reader/writer lock unit.
// ----------------------------------------------------------------------------
// Command words go in through the start/busy handshake. A scoreboard class
// keeps its own model of the ticket counters, the reader table and the
// skipped-ticket table, predicts each result word and compares it with what
// the block puts out on the strobe. Directed words come first, then random
// lock sessions over a small pool of requesters.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_ticket_reader_writer_lock_unit;
    import trwl_pkg::*;

    localparam int  N_RANDOM    = 1656;
    localparam longint CYC_LIMIT = 3000000;

    class lock_scoreboard;
        t_ticket     next_tk;
        t_ticket     serve_tk;
        bit          wr_held;
        logic [14:0] wr_owner;
        bit          rd_vld [MAX_READERS];
        logic [14:0] rd_owner [MAX_READERS];
        bit          sk_vld [MAX_SKIPPED];
        t_ticket     sk_tk [MAX_SKIPPED];
        t_out_word   pending [$];
        int          n_err;

        function void clear();
            next_tk = '0;
            serve_tk = '0;
            wr_held = 0;
            wr_owner = '0;
            foreach (rd_vld[i]) rd_vld[i] = 0;
            foreach (sk_vld[i]) sk_vld[i] = 0;
            pending.delete();
            n_err = 0;
        endfunction

        function int reader_of(logic [14:0] id);
            foreach (rd_vld[i]) if (rd_vld[i] && rd_owner[i] == id) return i;
            return -1;
        endfunction

        function bit readers_any();
            foreach (rd_vld[i]) if (rd_vld[i]) return 1;
            return 0;
        endfunction

        function int skip_of(t_ticket t);
            foreach (sk_vld[i]) if (sk_vld[i] && sk_tk[i] == t) return i;
            return -1;
        endfunction

        function bit owns(logic [14:0] id);
            return (wr_held && wr_owner == id) || reader_of(id) >= 0;
        endfunction

        function bit waiting(t_ticket t);
            t_ticket d, s;
            d = t - serve_tk;
            s = next_tk - serve_tk;
            return d < s;
        endfunction

        function void step_serving();
            int s;
            serve_tk = serve_tk + 1'b1;
            for (int k = 0; k <= MAX_SKIPPED; k++) begin
                s = skip_of(serve_tk);
                if (s < 0) break;
                sk_vld[s] = 0;
                serve_tk = serve_tk + 1'b1;
            end
        endfunction

        function logic [2:0] take_lock(logic [14:0] id, bit wr);
            if (wr) begin
                wr_held = 1;
                wr_owner = id;
                return ST_OK;
            end
            foreach (rd_vld[i]) if (!rd_vld[i]) begin
                rd_vld[i] = 1;
                rd_owner[i] = id;
                return ST_OK;
            end
            return ST_FULL;
        endfunction

        function void note_cmd(t_in_word c);
            t_out_word r;
            int        i;
            r = '0;
            case (c.opcode)
                OP_ACQUIRE: begin
                    if (owns(c.requester_id)) r.status = ST_DEADLOCK;
                    else if (t_ticket'(next_tk + 1'b1) == serve_tk) r.status = ST_FULL;
                    else begin
                        r.ticket_out = next_tk;
                        next_tk = next_tk + 1'b1;
                    end
                end
                OP_TRY_ACQUIRE: begin
                    if (owns(c.requester_id) || next_tk != serve_tk || wr_held
                        || (c.want_write && readers_any()))
                        r.status = ST_BUSY;
                    else begin
                        r.status = take_lock(c.requester_id, c.want_write);
                        r.wake_waiters = (r.status == ST_OK);
                    end
                end
                OP_POLL_GRANT: begin
                    if (!waiting(c.ticket_in) || c.ticket_in != serve_tk || wr_held
                        || (c.want_write && readers_any()))
                        r.status = ST_WAIT;
                    else begin
                        r.status = take_lock(c.requester_id, c.want_write);
                        if (r.status == ST_OK) begin
                            step_serving();
                            r.wake_waiters = !c.want_write;
                        end
                    end
                end
                OP_CANCEL: begin
                    if (!waiting(c.ticket_in)) r.status = ST_NOTHELD;
                    else if (c.ticket_in == serve_tk) begin
                        step_serving();
                        r.wake_waiters = 1;
                    end else if (skip_of(c.ticket_in) < 0) begin
                        r.status = ST_FULL;
                        foreach (sk_vld[j]) if (!sk_vld[j]) begin
                            sk_vld[j] = 1;
                            sk_tk[j] = c.ticket_in;
                            r.status = ST_OK;
                            break;
                        end
                    end
                end
                OP_RELEASE: begin
                    if (wr_held && wr_owner == c.requester_id) begin
                        wr_held = 0;
                        wr_owner = '0;
                        r.clear_lock_mark = 1;
                        r.wake_waiters = 1;
                    end else begin
                        i = reader_of(c.requester_id);
                        if (i < 0) r.status = ST_NOTHELD;
                        else begin
                            rd_vld[i] = 0;
                            r.clear_lock_mark = !readers_any();
                            r.wake_waiters = 1;
                        end
                    end
                end
                default: r.status = ST_NOTHELD;
            endcase
            pending.push_back(r);
        endfunction

        task report(string what, int got, int exp);
            $display("MISMATCH %s: got %0d expected %0d", what, got, exp);
            n_err++;
        endtask

        task check_res(t_out_word g);
            t_out_word e;
            if (pending.size() == 0) begin
                report("result with none pending, status", g.status, 0);
                return;
            end
            e = pending.pop_front();
            if (g.status !== e.status) report("status", g.status, e.status);
            if (g.ticket_out !== e.ticket_out) report("ticket_out", g.ticket_out, e.ticket_out);
            if (g.clear_lock_mark !== e.clear_lock_mark)
                report("clear_lock_mark", g.clear_lock_mark, e.clear_lock_mark);
            if (g.wake_waiters !== e.wake_waiters)
                report("wake_waiters", g.wake_waiters, e.wake_waiters);
        endtask
    endclass

    logic      i_clk;
    logic      i_rst_n;
    logic      start;
    logic      busy;
    t_in_word  i_cmd;
    logic      o_strobe;
    t_out_word o_res;

    lock_scoreboard sb;
    longint    cycles = 0;
    bit        idle_gaps;
    logic [14:0] ids [8];

    ticket_reader_writer_lock_unit DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_cmd(i_cmd), .o_strobe(o_strobe), .o_res(o_res)
    );

    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n && o_strobe) sb.check_res(o_res);
        if (cycles > CYC_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    task send_word(logic [2:0] op, logic [14:0] id, bit wr, logic [15:0] tk);
        int gap;
        if (idle_gaps && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 9);
            repeat (gap) @(negedge i_clk);
        end
        @(negedge i_clk);
        start <= 1;
        i_cmd <= '{opcode: op, requester_id: id, want_write: wr, ticket_in: tk};
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sb.note_cmd(i_cmd);
        @(negedge i_clk);
        start <= 0;
        i_cmd <= '0;
    endtask

    task drain();
        while (sb.pending.size() != 0) @(negedge i_clk);
    endtask

    function logic [15:0] pick_ticket();
        case ($urandom_range(0, 9))
            0: return 16'($urandom);
            1, 2: return sb.serve_tk;
            3: return sb.next_tk;
            default: return sb.serve_tk + 16'($urandom_range(0, 5));
        endcase
    endfunction

    initial begin
        int   p;
        logic [2:0] op;
        logic [14:0] id;
        sb = new();
        sb.clear();
        idle_gaps = 0;
        start = 0;
        i_cmd = '0;
        i_rst_n = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;
        foreach (ids[i]) ids[i] = 15'($urandom);
        ids[0] = '0;
        ids[1] = 15'h7FFF;

        // directed: extremes, every opcode, corner cases
        send_word(OP_RELEASE, 15'h7FFF, 0, 16'hFFFF);
        send_word(OP_CANCEL, 0, 0, 16'h0000);
        send_word(OP_POLL_GRANT, 0, 1, 16'hFFFF);
        send_word(3'd5, 15'h7FFF, 1, 16'hFFFF);
        send_word(3'd7, 0, 0, 0);
        send_word(OP_TRY_ACQUIRE, 15'h7FFF, 1, 0);
        send_word(OP_ACQUIRE, 15'h7FFF, 0, 0);
        send_word(OP_TRY_ACQUIRE, 15'h1234, 0, 0);
        send_word(OP_RELEASE, 15'h7FFF, 0, 0);
        send_word(OP_ACQUIRE, 0, 0, 0);
        send_word(OP_ACQUIRE, 1, 1, 0);
        send_word(OP_ACQUIRE, 2, 0, 0);
        send_word(OP_CANCEL, 0, 0, 16'd2);
        send_word(OP_CANCEL, 0, 0, 16'd2);
        send_word(OP_POLL_GRANT, 0, 0, 16'd0);
        send_word(OP_POLL_GRANT, 1, 1, 16'd1);
        send_word(OP_RELEASE, 0, 0, 0);
        send_word(OP_POLL_GRANT, 1, 1, 16'd1);
        send_word(OP_ACQUIRE, 0, 0, 0);
        send_word(OP_RELEASE, 1, 1, 0);
        send_word(OP_POLL_GRANT, 0, 0, sb.serve_tk);
        send_word(OP_CANCEL, 0, 0, sb.serve_tk);
        drain();

        // reader table full: 17 try_acquires by distinct ids
        for (int i = 0; i < 17; i++) send_word(OP_TRY_ACQUIRE, 15'(100 + i), 0, 0);
        for (int i = 0; i < 17; i++) send_word(OP_RELEASE, 15'(100 + i), 0, 0);

        // skipped table full: 18 tickets behind the served one
        for (int i = 0; i < 19; i++) send_word(OP_ACQUIRE, 15'(200 + i), 0, 0);
        for (int i = 1; i < 19; i++) send_word(OP_CANCEL, 0, 0, sb.serve_tk + 16'(i));
        send_word(OP_CANCEL, 0, 0, sb.serve_tk);
        drain();

        // random sessions
        idle_gaps = 1;
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == N_RANDOM * 3 / 4) idle_gaps = 0;
            if (n == N_RANDOM / 2) drain();
            p = $urandom_range(0, 99);
            id = ($urandom_range(0, 19) == 0) ? 15'($urandom) : ids[$urandom_range(0, 7)];
            if (p < 22) op = OP_ACQUIRE;
            else if (p < 32) op = OP_TRY_ACQUIRE;
            else if (p < 62) op = OP_POLL_GRANT;
            else if (p < 74) op = OP_CANCEL;
            else if (p < 97) op = OP_RELEASE;
            else op = 3'($urandom_range(5, 7));
            send_word(op, id, 1'($urandom), pick_ticket());
        end

        drain();
        repeat (200) @(posedge i_clk);
        if (sb.n_err == 0 && sb.pending.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
